// File: rtl/hcvs_pkg.sv
package hcvs_pkg;

    // default chain length
    localparam int NUM_BEADS_DEF = 8;

    // payload widths
    localparam int IN_DATA_W  = 104;
    localparam int OUT_DATA_W = 72;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 31;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_TIME_STEP   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_OMEGA_SQ    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_REST_LENGTH = 2'd2;

    // register reset values
    localparam logic [15:0] TIME_STEP_RST   = 16'd655;
    localparam logic [23:0] OMEGA_SQ_RST    = 24'd65536;
    localparam logic [30:0] REST_LENGTH_RST = 31'd65536;

    // mode codes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ACC_MUL,
        OP_ACC_WR,
        OP_POS_MUL1,
        OP_POS_INNER,
        OP_POS_MUL2,
        OP_POS_WR,
        OP_VEL_AMUL,
        OP_VEL_ACC,
        OP_VEL_MUL,
        OP_VEL_WR
    } op_t;

    typedef struct packed {
        op_t  op;
        logic capture;
    } cmd_t;

    // p / 2^k rounded to nearest, ties toward plus infinity
    function automatic logic signed [63:0] rnd(input logic signed [63:0] p, input int k);
        logic signed [63:0] w;
        w = p + (64'sd1 <<< (k - 1));
        return w >>> k;
    endfunction

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < -64'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/harmonic_chain_verlet_step.sv
// Harmonic bead chain, one velocity Verlet step per step request.
// Input stream s_*: tuser is the mode (0 loads one bead, 1 runs a step).
// tdata carries bead_index, load_position, load_velocity, wall_position.
// A load request writes one bead (indexes past the chain are dropped)
// and returns nothing; it passes through a single load state back to idle.
// A step request runs three passes over the beads through one shared
// multiplier: accelerations (multiply, write per bead), positions
// (multiply, inner sum, multiply, write per bead), then new accelerations
// and velocities (multiply, new acceleration, multiply, write per bead).
// Output stream m_*: NUM_BEADS results, bead 0 first, tlast on the last.
// One request at a time: s_tready is low from acceptance until the last
// result is taken. A stalled receiver simply holds the block in its
// output phase; nothing is dropped.
// The user makes configuration writes (cfg_we, cfg_addr, cfg_data) only while idle; the block does not enforce this.
// Reset restores register defaults and clears bead positions and velocities; accelerations are not reset.
module harmonic_chain_verlet_step
    import hcvs_pkg::*;
#(
    parameter int NUM_BEADS = NUM_BEADS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // bead_index, load_position, load_velocity, wall_position, zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // mode
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_index, out_position, out_velocity, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast
);

    localparam int IDX_W = $clog2(NUM_BEADS);

    cmd_t             cmd;
    logic [IDX_W-1:0] idx;

    hcvs_ctrl #(.NUM_BEADS(NUM_BEADS), .IDX_W(IDX_W)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .idx      (idx)
    );

    hcvs_dp #(.NUM_BEADS(NUM_BEADS), .IDX_W(IDX_W)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tdata  (s_tdata),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .idx      (idx)
    );

endmodule

// File: rtl/hcvs_ctrl.sv
module hcvs_ctrl
    import hcvs_pkg::*;
#(
    parameter int NUM_BEADS = NUM_BEADS_DEF,
    parameter int IDX_W     = $clog2(NUM_BEADS)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tuser,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic             m_tlast,
    output cmd_t             cmd,
    output logic [IDX_W-1:0] idx
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ACC_MUL,
        ST_ACC_WR,
        ST_POS_MUL1,
        ST_POS_INNER,
        ST_POS_MUL2,
        ST_POS_WR,
        ST_VEL_AMUL,
        ST_VEL_ACC,
        ST_VEL_MUL,
        ST_VEL_WR,
        ST_OUT
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BEADS - 1);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             accept;
    logic             at_last;

    assign accept  = s_tvalid && s_tready;
    assign at_last = (idx_reg == LAST_IDX);

    // next state and bead counter
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next   = '0;
                    state_next = (s_tuser == MODE_STEP) ? ST_ACC_MUL : ST_LOAD;
                end
            end
            ST_LOAD:      state_next = ST_IDLE;
            ST_ACC_MUL:   state_next = ST_ACC_WR;
            ST_ACC_WR:
            begin
                idx_next   = at_last ? '0 : idx_reg + 1'b1;
                state_next = at_last ? ST_POS_MUL1 : ST_ACC_MUL;
            end
            ST_POS_MUL1:  state_next = ST_POS_INNER;
            ST_POS_INNER: state_next = ST_POS_MUL2;
            ST_POS_MUL2:  state_next = ST_POS_WR;
            ST_POS_WR:
            begin
                idx_next   = at_last ? '0 : idx_reg + 1'b1;
                state_next = at_last ? ST_VEL_AMUL : ST_POS_MUL1;
            end
            ST_VEL_AMUL:  state_next = ST_VEL_ACC;
            ST_VEL_ACC:   state_next = ST_VEL_MUL;
            ST_VEL_MUL:   state_next = ST_VEL_WR;
            ST_VEL_WR:
            begin
                idx_next   = at_last ? '0 : idx_reg + 1'b1;
                state_next = at_last ? ST_OUT : ST_VEL_AMUL;
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    idx_next   = at_last ? '0 : idx_reg + 1'b1;
                    state_next = at_last ? ST_IDLE : ST_OUT;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // commands to the datapath
    always_comb
    begin
        cmd.capture = accept;
        case (state_reg)
            ST_LOAD:      cmd.op = OP_LOAD;
            ST_ACC_MUL:   cmd.op = OP_ACC_MUL;
            ST_ACC_WR:    cmd.op = OP_ACC_WR;
            ST_POS_MUL1:  cmd.op = OP_POS_MUL1;
            ST_POS_INNER: cmd.op = OP_POS_INNER;
            ST_POS_MUL2:  cmd.op = OP_POS_MUL2;
            ST_POS_WR:    cmd.op = OP_POS_WR;
            ST_VEL_AMUL:  cmd.op = OP_VEL_AMUL;
            ST_VEL_ACC:   cmd.op = OP_VEL_ACC;
            ST_VEL_MUL:   cmd.op = OP_VEL_MUL;
            ST_VEL_WR:    cmd.op = OP_VEL_WR;
            default:      cmd.op = OP_NONE;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tlast  = m_tvalid && at_last;
    assign idx      = idx_reg;

`ifndef SYNTH
    // never take a request while results are pending
    assert property (@(posedge clk) disable iff (!rst_n) s_tready |-> !m_tvalid)
        else $error("input taken while output pending");
    // the final result returns the block to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("not idle after last result");
    // a load gives no result and keeps the input blocked in the cycle after acceptance
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == MODE_LOAD) |=> (!s_tready && !m_tvalid))
        else $error("load handling wrong");
    // a step never starts emitting results at once
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == MODE_STEP) |=> !m_tvalid)
        else $error("result too early");
`endif

endmodule

// File: rtl/hcvs_dp.sv
module hcvs_dp
    import hcvs_pkg::*;
#(
    parameter int NUM_BEADS = NUM_BEADS_DEF,
    parameter int IDX_W     = $clog2(NUM_BEADS)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  cmd_t                  cmd,
    input  logic [IDX_W-1:0]      idx
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BEADS - 1);

    logic [15:0] time_step_reg;
    logic [23:0] omega_sq_reg;

    logic [IN_DATA_W-1:0] in_reg;
    logic [2:0]           in_bead;
    logic signed [31:0]   in_pos, in_vel, in_wall;

    logic signed [31:0] pos_reg [NUM_BEADS];
    logic signed [31:0] vel_reg [NUM_BEADS];
    logic signed [31:0] acc_reg [NUM_BEADS];

    logic signed [59:0] prod_reg;
    logic signed [34:0] tmp_reg;

    logic [IDX_W-1:0]   idx_m1, idx_p1;
    logic signed [31:0] x_cur, x_left, x_right, v_cur, a_cur;
    logic signed [34:0] d_neg;
    logic signed [34:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [59:0] mul_p;
    logic signed [63:0] prod_ext;
    logic [6:0]         load_ext;
    logic [7:0]         out_idx_ext;

    // configuration registers, the rest length drops out of the force
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg   <= TIME_STEP_RST;
            omega_sq_reg    <= OMEGA_SQ_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_TIME_STEP:   time_step_reg   <= cfg_data[15:0];
                REG_OMEGA_SQ:    omega_sq_reg    <= cfg_data[23:0];
                default:         ;
            endcase
        end
    end

    // captured request
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_reg <= s_tdata;
        end
    end

    assign in_bead  = in_reg[2:0];
    assign in_pos   = in_reg[34:3];
    assign in_vel   = in_reg[66:35];
    assign in_wall  = in_reg[98:67];
    assign load_ext = 7'(in_bead);

    // neighbor reads, walls at the ends
    assign idx_m1  = (idx == '0) ? idx : idx - 1'b1;
    assign idx_p1  = (idx == LAST_IDX) ? idx : idx + 1'b1;
    assign x_cur   = pos_reg[idx];
    assign v_cur   = vel_reg[idx];
    assign a_cur   = acc_reg[idx];
    assign x_left  = (idx == '0) ? 32'sd0 : pos_reg[idx_m1];
    assign x_right = (idx == LAST_IDX) ? in_wall : pos_reg[idx_p1];
    // the rest length cancels between the two springs
    assign d_neg   = 35'(x_left) + 35'(x_right) - (35'(x_cur) <<< 1);

    // shared multiplier operands
    always_comb
    begin
        case (cmd.op)
            OP_ACC_MUL, OP_VEL_AMUL:
            begin
                mul_a = d_neg;
                mul_b = $signed({1'b0, omega_sq_reg});
            end
            OP_POS_MUL1:
            begin
                mul_a = 35'(a_cur);
                mul_b = $signed({9'd0, time_step_reg});
            end
            OP_POS_MUL2:
            begin
                mul_a = tmp_reg;
                mul_b = $signed({9'd0, time_step_reg});
            end
            OP_VEL_MUL:
            begin
                mul_a = 35'(a_cur) + tmp_reg;
                mul_b = $signed({9'd0, time_step_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p    = 60'(mul_a) * 60'(mul_b);
    assign prod_ext = 64'(prod_reg);

    // product and scratch registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_ACC_MUL, OP_VEL_AMUL, OP_POS_MUL1, OP_POS_MUL2, OP_VEL_MUL:
                prod_reg <= mul_p;
            OP_POS_INNER:
                tmp_reg <= 35'(64'(v_cur) + rnd(prod_ext, 17));
            OP_VEL_ACC:
                tmp_reg <= 35'(sat32(rnd(prod_ext, 16)));
            default: ;
        endcase
    end

    // bead state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BEADS; i++)
            begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
            end
        end
        else
        begin
            case (cmd.op)
                OP_LOAD:
                begin
                    if (load_ext < 7'(NUM_BEADS))
                    begin
                        pos_reg[load_ext[IDX_W-1:0]] <= in_pos;
                        vel_reg[load_ext[IDX_W-1:0]] <= in_vel;
                    end
                end
                OP_POS_WR:
                    pos_reg[idx] <= sat32(64'(x_cur) + rnd(prod_ext, 16));
                OP_VEL_WR:
                    vel_reg[idx] <= sat32(64'(v_cur) + rnd(prod_ext, 17));
                default: ;
            endcase
        end
    end

    // accelerations, written before every read
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_ACC_WR: acc_reg[idx] <= sat32(rnd(prod_ext, 16));
            OP_VEL_WR: acc_reg[idx] <= tmp_reg[31:0];
            default:   ;
        endcase
    end

    // result payload
    assign out_idx_ext = 8'(idx);
    assign m_tdata     = {5'd0, v_cur, x_cur, out_idx_ext[2:0]};

endmodule
